@@ sv/mlfq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_pkg: shared types and constants
// Payload structs, status codes and sizes for the feedback-queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int unsigned MaxProcs  = 16;
  localparam int unsigned MaxCpus   = 4;
  localparam int unsigned NumLevels = 3;
  localparam int unsigned PW = $clog2(MaxProcs);
  localparam int unsigned CW = $clog2(MaxCpus);

  localparam logic [2:0] RegQ0    = 3'd0;
  localparam logic [2:0] RegQ1    = 3'd1;
  localparam logic [2:0] RegBoost = 3'd2;
  localparam logic [2:0] RegNcpu  = 3'd3;
  localparam logic [2:0] RegNproc = 3'd4;

  localparam logic [1:0] StEmpty = 2'd0;
  localparam logic [1:0] StReady = 2'd1;
  localparam logic [1:0] StRun   = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  typedef struct packed {
    logic        op;
    logic [3:0]  proc_slot;
    logic [15:0] arrival;
    logic [15:0] burst;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  cpu_index;
    logic        busy_res;
    logic [3:0]  running_slot;
    logic        completed;
    logic [15:0] completion_tick;
    logic [15:0] tick;
    logic        all_done;
    logic        last;
  } out_item_t;

endpackage
`default_nettype wire

@@ sv/mlfq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_ram: generic single-port ram
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module mlfq_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write or registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

@@ sv/mlfq_multicpu_scheduler_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_multicpu_scheduler_top: three-level feedback-queue scheduler
// A load item writes a process entry; a tick item runs boost, per-cpu
// selection over the process table and one unit of service per cpu.
// ----------------------------------------------------------------------------
// A load writes its entry and returns to idle. A tick walks the process table
// one entry per cycle for boost, for each scheduled cpu's selection and for
// the done check, and reads and updates the remaining-burst ram once per busy
// cpu; a stalled output holds the emit of each cpu result.
// One item at a time; results leave through one output register.
// Reset: all entries not loaded, level 0, cpus idle, counters zero.
// ----------------------------------------------------------------------------
module mlfq_multicpu_scheduler_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire mlfq_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output mlfq_pkg::out_item_t      out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_idx_i,
  input  wire logic [9:0]          cfg_data_i
);
  localparam int unsigned NP = mlfq_pkg::MaxProcs;
  localparam int unsigned NC = mlfq_pkg::MaxCpus;
  localparam int unsigned PW = mlfq_pkg::PW;
  localparam int unsigned CW = mlfq_pkg::CW;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_LOAD   = 10'b0000000010,
    S_BOOST  = 10'b0000000100,
    S_SCAN   = 10'b0000001000,
    S_DISP   = 10'b0000010000,
    S_SRD    = 10'b0000100000,
    S_SWAIT  = 10'b0001000000,
    S_SWR    = 10'b0010000000,
    S_DONE   = 10'b0100000000,
    S_EMIT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [7:0] q0_q, q1_q;
  logic [9:0] bper_q;
  logic [2:0] ncpu_q;
  logic [4:0] nproc_q;

  // state
  logic [15:0] arr_q [NP];
  logic [1:0]  lvl_q [NP];
  logic [1:0]  st_q  [NP];
  logic [CW-1:0] pcpu_q [NP];
  logic [PW:0] cur_q [NC];
  logic [7:0]  qleft_q [NC];
  logic [15:0] tick_q;
  logic [9:0]  bcnt_q;

  // sequencer
  mlfq_pkg::in_item_t item_q;
  logic [PW:0]   idx_q;
  logic [CW:0]   cpu_q;
  logic [PW:0]   best_q;
  logic [1:0]    blvl_q;
  logic          done_q;
  logic          ran_q [NC];
  logic [PW-1:0] rslot_q [NC];
  logic          fin_q [NC];
  logic          bflag_q;

  logic [2:0] ncl;
  logic [4:0] npl;
  assign ncl = (ncpu_q > 3'(NC)) ? 3'(NC) : ncpu_q;
  assign npl = (nproc_q > 5'(NP)) ? 5'(NP) : nproc_q;

  logic [15:0] ctick;
  assign ctick = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : 16'hFFFF;

  // remaining-burst ram
  logic          ram_we;
  logic [PW-1:0] ram_addr;
  logic [15:0]   ram_wdata, ram_rdata;
  mlfq_ram #(.Width(16), .Depth(NP)) u_rem (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  logic [CW-1:0] cix;
  logic [PW-1:0] pix, cur_slot;
  assign cix = cpu_q[CW-1:0];
  assign pix = idx_q[PW-1:0];
  assign cur_slot = cur_q[cix][PW-1:0];

  logic [15:0] rem_dec;
  assign rem_dec = (ram_rdata != 16'd0) ? ram_rdata - 16'd1 : 16'd0;

  always_comb begin
    ram_we = 1'b0;
    ram_addr = cur_slot;
    ram_wdata = rem_dec;
    if (state_q == S_LOAD) begin
      ram_we = 1'b1;
      ram_addr = item_q.proc_slot[PW-1:0];
      ram_wdata = item_q.burst;
    end else if (state_q == S_SWR) begin
      ram_we = 1'b1;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = in_valid_i && !in_data_i.op ? S_LOAD : S_BOOST;
      S_LOAD:  state_d = S_IDLE;
      S_BOOST: state_d = (idx_q == 5'(NP - 1)) ? S_SCAN : S_BOOST;
      S_SCAN:  begin
        if ({1'b0, cpu_q} >= {1'b0, ncl}) state_d = S_SRD;
        else if (idx_q == 5'(NP - 1)) state_d = S_DISP;
      end
      S_DISP:  state_d = S_SCAN;
      S_SRD:   begin
        if ({1'b0, cpu_q} >= {1'b0, ncl}) state_d = S_DONE;
        else if (cur_q[cix][PW]) state_d = S_SRD;
        else state_d = S_SWAIT;
      end
      S_SWAIT: state_d = S_SWR;
      S_SWR:   state_d = S_SRD;
      S_DONE:  begin
        if (idx_q == 5'(NP - 1)) state_d = (ncl == 3'd0) ? S_IDLE : S_EMIT;
      end
      S_EMIT:  begin
        if (!out_valid_o || out_ready_i) begin
          if ({1'b0, cpu_q} + 4'd1 >= {1'b0, ncl}) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  logic [1:0] slvl;
  logic       elig;
  assign slvl = lvl_q[pix];
  assign elig = (5'(idx_q) < npl) && (st_q[pix] == mlfq_pkg::StReady)
                && (arr_q[pix] <= tick_q) && (slvl < blvl_q);

  logic [1:0] rlvl;
  logic       timed;
  assign rlvl = lvl_q[cur_slot];
  assign timed = rlvl < 2'(mlfq_pkg::NumLevels - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      q0_q <= 8'd4; q1_q <= 8'd8; bper_q <= 10'd30; ncpu_q <= 3'd1; nproc_q <= 5'd0;
      for (int i = 0; i < NP; i++) begin
        lvl_q[i] <= 2'd0; st_q[i] <= mlfq_pkg::StEmpty;
      end
      for (int c = 0; c < NC; c++) begin
        cur_q[c] <= 5'(NP); qleft_q[c] <= 8'd0;
      end
      tick_q <= 16'd0; bcnt_q <= 10'd0;
      out_valid_o <= 1'b0;
      idx_q <= '0; cpu_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_o && out_ready_i && state_q != S_EMIT) out_valid_o <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mlfq_pkg::RegQ0:    q0_q <= cfg_data_i[7:0];
          mlfq_pkg::RegQ1:    q1_q <= cfg_data_i[7:0];
          mlfq_pkg::RegBoost: bper_q <= cfg_data_i;
          mlfq_pkg::RegNcpu:  ncpu_q <= cfg_data_i[2:0];
          mlfq_pkg::RegNproc: nproc_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          idx_q <= '0; cpu_q <= '0;
          best_q <= 5'(NP); blvl_q <= 2'(mlfq_pkg::NumLevels);
          done_q <= 1'b1;
          bflag_q <= (bcnt_q >= bper_q);
          if (in_valid_i) item_q <= in_data_i;
          if (in_valid_i && in_data_i.op && bcnt_q >= bper_q) bcnt_q <= 10'd0;
        end
        S_LOAD: begin
          arr_q[item_q.proc_slot[PW-1:0]] <= item_q.arrival;
          lvl_q[item_q.proc_slot[PW-1:0]] <= 2'd0;
          st_q[item_q.proc_slot[PW-1:0]] <= mlfq_pkg::StReady;
          for (int c = 0; c < NC; c++) begin
            if (cur_q[c] == {1'b0, item_q.proc_slot[PW-1:0]}) begin
              cur_q[c] <= 5'(NP); qleft_q[c] <= 8'd0;
            end
          end
        end
        S_BOOST: begin
          if (bflag_q && 5'(idx_q) < npl &&
              (st_q[pix] == mlfq_pkg::StReady || st_q[pix] == mlfq_pkg::StRun)) begin
            lvl_q[pix] <= 2'd0;
            if (st_q[pix] == mlfq_pkg::StRun) qleft_q[pcpu_q[pix]] <= q0_q;
          end
          idx_q <= (idx_q == 5'(NP - 1)) ? '0 : idx_q + 5'd1;
        end
        S_SCAN: begin
          if ({1'b0, cpu_q} >= {1'b0, ncl}) begin
            cpu_q <= '0;
          end else begin
            if (elig) begin
              best_q <= {1'b0, pix}; blvl_q <= slvl;
            end
            idx_q <= (idx_q == 5'(NP - 1)) ? '0 : idx_q + 5'd1;
          end
        end
        S_DISP: begin
          if (!best_q[PW]) begin
            if (cur_q[cix][PW] || lvl_q[best_q[PW-1:0]] < rlvl) begin
              if (!cur_q[cix][PW]) st_q[cur_slot] <= mlfq_pkg::StReady;
              cur_q[cix] <= best_q;
              qleft_q[cix] <= (lvl_q[best_q[PW-1:0]] == 2'd0) ? q0_q :
                (lvl_q[best_q[PW-1:0]] < 2'(mlfq_pkg::NumLevels - 1)) ? q1_q : 8'd0;
              st_q[best_q[PW-1:0]] <= mlfq_pkg::StRun;
              pcpu_q[best_q[PW-1:0]] <= cix;
            end
          end
          best_q <= 5'(NP); blvl_q <= 2'(mlfq_pkg::NumLevels);
          cpu_q <= cpu_q + 3'd1;
        end
        S_SRD: begin
          if ({1'b0, cpu_q} >= {1'b0, ncl}) begin
            cpu_q <= '0; idx_q <= '0;
          end else begin
            ran_q[cix] <= !cur_q[cix][PW];
            rslot_q[cix] <= cur_slot;
            fin_q[cix] <= 1'b0;
            if (cur_q[cix][PW]) cpu_q <= cpu_q + 3'd1;
          end
        end
        S_SWAIT: ;
        S_SWR: begin
          if (timed && qleft_q[cix] != 8'd0) qleft_q[cix] <= qleft_q[cix] - 8'd1;
          if (rem_dec == 16'd0) begin
            st_q[cur_slot] <= mlfq_pkg::StDone;
            cur_q[cix] <= 5'(NP);
            fin_q[cix] <= 1'b1;
          end else if (timed && qleft_q[cix] <= 8'd1) begin
            lvl_q[cur_slot] <= rlvl + 2'd1;
            st_q[cur_slot] <= mlfq_pkg::StReady;
            cur_q[cix] <= 5'(NP);
          end
          cpu_q <= cpu_q + 3'd1;
        end
        S_DONE: begin
          if (5'(idx_q) < npl && st_q[pix] != mlfq_pkg::StDone) done_q <= 1'b0;
          idx_q <= (idx_q == 5'(NP - 1)) ? '0 : idx_q + 5'd1;
          if (idx_q == 5'(NP - 1) && ncl == 3'd0) begin
            tick_q <= ctick;
            if (bcnt_q != 10'h3FF) bcnt_q <= bcnt_q + 10'd1;
          end
        end
        S_EMIT: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o <= 1'b1;
            out_data_o.cpu_index <= 2'(cpu_q);
            out_data_o.busy_res <= ran_q[cix];
            out_data_o.running_slot <= ran_q[cix] ? 4'(rslot_q[cix]) : 4'd0;
            out_data_o.completed <= fin_q[cix];
            out_data_o.completion_tick <= fin_q[cix] ? ctick : 16'd0;
            out_data_o.tick <= tick_q;
            out_data_o.all_done <= done_q;
            out_data_o.last <= ({1'b0, cpu_q} + 4'd1 == {1'b0, ncl});
            cpu_q <= cpu_q + 3'd1;
            if ({1'b0, cpu_q} + 4'd1 >= {1'b0, ncl}) begin
              tick_q <= ctick;
              if (bcnt_q != 10'h3FF) bcnt_q <= bcnt_q + 10'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
